// ===== rtl/core/gprm_pkg.sv =====
`timescale 1ns / 1ps

package gprm_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned SCALED_W    = 25;
  localparam int unsigned LEVEL_W     = 25;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 152;

  // Gain in unsigned Q2.14.
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned GAIN_FRAC = 14;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  // Channel count register.
  localparam int unsigned CHAN_W = 2;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

  // Accumulation and level arithmetic.
  localparam int unsigned SQ_W       = 2 * SCALED_W;
  localparam int unsigned SUM_W      = 61;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned SQV_W      = 2 * SQRT_STEPS;
  localparam int unsigned SREM_W     = ROOT_W + 2;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  // Frame queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified frame as it travels through the queue.
  typedef struct packed {
    logic signed [SCALED_W-1:0] left_scaled;
    logic signed [SCALED_W-1:0] right_scaled;
    logic                       last_frame;
    logic                       stereo;
  } frame_t;

  // Status of the level unit as seen by the back part.
  typedef struct packed {
    logic busy;
    logic done;
  } lvl_stat_t;

endpackage

// ===== rtl/core/gprm_front.sv =====
`timescale 1ns / 1ps

module gprm_front
  import gprm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IN_TDATA_W-1:0] in_data_i,
  input  logic                  in_last_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output frame_t                q_entry_o
);

  logic [GAIN_W-1:0]           gain_q, gain_d;
  logic [CHAN_W-1:0]           chan_q, chan_d;
  logic                        stereo;
  logic signed [SAMPLE_W-1:0]  left_in, right_in;
  logic signed [GAIN_W:0]      gain_s;
  logic signed [SAMPLE_W+GAIN_W:0] left_prod, right_prod;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gain_d = gain_q;
    chan_d = chan_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MASTER_GAIN: begin
          gain_d = (cfg_data_i > GAIN_MAX) ? GAIN_MAX : cfg_data_i;
        end
        REG_CHANNEL_COUNT: begin
          chan_d = cfg_data_i[CHAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      chan_q <= CHAN_RESET;
    end else begin
      gain_q <= gain_d;
      chan_q <= chan_d;
    end
  end

  // Counts of two and three both mean stereo.
  assign stereo   = chan_q[1];
  assign left_in  = in_data_i[SAMPLE_W-1:0];
  assign right_in = in_data_i[2*SAMPLE_W-1:SAMPLE_W];
  assign gain_s   = $signed({1'b0, gain_q});

  assign left_prod  = left_in * gain_s;
  assign right_prod = right_in * gain_s;

  // Taking the bits above the fraction is an arithmetic shift, so it floors.
  always_comb begin
    q_entry_o.left_scaled  = left_prod[GAIN_FRAC +: SCALED_W];
    q_entry_o.right_scaled = stereo ? right_prod[GAIN_FRAC +: SCALED_W] : '0;
    q_entry_o.last_frame   = in_last_i;
    q_entry_o.stereo       = stereo;
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ===== rtl/core/gprm_queue.sv =====
`timescale 1ns / 1ps

module gprm_queue
  import gprm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output frame_t head_o,
  output logic   empty_o
);

  frame_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/gprm_level.sv =====
`timescale 1ns / 1ps

module gprm_level
  import gprm_pkg::*;
#(
  parameter int unsigned TALLY_W = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   sum_l_i,
  input  logic [SUM_W-1:0]   sum_r_i,
  input  logic [TALLY_W-1:0] count_i,
  output lvl_stat_t          stat_o,
  output logic [ROOT_W-1:0]  root_l_o,
  output logic [ROOT_W-1:0]  root_r_o
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_DIV  = 2'd1;
  localparam logic [1:0] L_SQRT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [TALLY_W-1:0] n_q;

  // Restoring division, one quotient bit per cycle for each channel.
  logic [SUM_W-1:0]   dq_l_q, dq_r_q, dq_l_d, dq_r_d;
  logic [TALLY_W-1:0] rem_l_q, rem_r_q, rem_l_d, rem_r_d;
  logic [TALLY_W:0]   dtr_l, dtr_r;
  logic               dge_l, dge_r;

  // Digit-by-digit square root, two radicand bits per cycle.
  logic [SQV_W-1:0]   sv_l_q, sv_r_q;
  logic [SREM_W-1:0]  sr_l_q, sr_r_q, sr_l_d, sr_r_d;
  logic [ROOT_W-1:0]  rt_l_q, rt_r_q;
  logic [SREM_W+1:0]  cand_l, cand_r, trial_l, trial_r;
  logic               sge_l, sge_r;

  always_comb begin
    dtr_l  = {rem_l_q, dq_l_q[SUM_W-1]};
    dtr_r  = {rem_r_q, dq_r_q[SUM_W-1]};
    dge_l  = dtr_l >= {1'b0, n_q};
    dge_r  = dtr_r >= {1'b0, n_q};
    rem_l_d = dge_l ? TALLY_W'(dtr_l - {1'b0, n_q}) : TALLY_W'(dtr_l);
    rem_r_d = dge_r ? TALLY_W'(dtr_r - {1'b0, n_q}) : TALLY_W'(dtr_r);
    dq_l_d = {dq_l_q[SUM_W-2:0], dge_l};
    dq_r_d = {dq_r_q[SUM_W-2:0], dge_r};

    cand_l  = {sr_l_q, sv_l_q[SQV_W-1 -: 2]};
    cand_r  = {sr_r_q, sv_r_q[SQV_W-1 -: 2]};
    trial_l = (SREM_W+2)'({rt_l_q, 2'b01});
    trial_r = (SREM_W+2)'({rt_r_q, 2'b01});
    sge_l   = cand_l >= trial_l;
    sge_r   = cand_r >= trial_r;
    sr_l_d  = sge_l ? SREM_W'(cand_l - trial_l) : SREM_W'(cand_l);
    sr_r_d  = sge_r ? SREM_W'(cand_r - trial_r) : SREM_W'(cand_r);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          state_d = L_DIV;
          cnt_d   = '0;
        end
      end
      L_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = L_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      L_SQRT: begin
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = L_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      dq_l_q  <= sum_l_i;
      dq_r_q  <= sum_r_i;
      rem_l_q <= '0;
      rem_r_q <= '0;
      n_q     <= count_i;
    end else if (state_q == L_DIV) begin
      dq_l_q  <= dq_l_d;
      dq_r_q  <= dq_r_d;
      rem_l_q <= rem_l_d;
      rem_r_q <= rem_r_d;
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        sv_l_q <= SQV_W'(dq_l_d);
        sv_r_q <= SQV_W'(dq_r_d);
        sr_l_q <= '0;
        sr_r_q <= '0;
        rt_l_q <= '0;
        rt_r_q <= '0;
      end
    end else if (state_q == L_SQRT) begin
      sv_l_q <= {sv_l_q[SQV_W-3:0], 2'b00};
      sv_r_q <= {sv_r_q[SQV_W-3:0], 2'b00};
      sr_l_q <= sr_l_d;
      sr_r_q <= sr_r_d;
      rt_l_q <= {rt_l_q[ROOT_W-2:0], sge_l};
      rt_r_q <= {rt_r_q[ROOT_W-2:0], sge_r};
    end
  end

  assign stat_o.busy = (state_q != L_IDLE);
  assign stat_o.done = done_q;
  assign root_l_o    = rt_l_q;
  assign root_r_o    = rt_r_q;

endmodule

// ===== rtl/core/gprm_back.sv =====
`timescale 1ns / 1ps

module gprm_back
  import gprm_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 4096,
  parameter int unsigned TALLY_W     = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  frame_t                 q_head_i,
  output logic                   q_pop_o,
  output logic                   lvl_start_o,
  output logic [SUM_W-1:0]       lvl_sum_l_o,
  output logic [SUM_W-1:0]       lvl_sum_r_o,
  output logic [TALLY_W-1:0]     lvl_count_o,
  input  lvl_stat_t              lvl_stat_i,
  input  logic [ROOT_W-1:0]      lvl_root_l_i,
  input  logic [ROOT_W-1:0]      lvl_root_r_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_last_o
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_ACC   = 2'd1;
  localparam logic [1:0] B_LEVEL = 2'd2;
  localparam logic [1:0] B_OUT   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                slot_free, load_out, pop;

  frame_t              cur_q;
  logic                done_q;
  logic [LEVEL_W-1:0]  mag_l_q, mag_r_q, mag_l, mag_r;
  logic [SQ_W-1:0]     sq_l_q, sq_r_q;

  logic [SUM_W-1:0]    sum_l_q, sum_r_q, sum_l_n, sum_r_n;
  logic [SUM_W:0]      add_l, add_r;
  logic [LEVEL_W-1:0]  pk_l_q, pk_r_q, pk_l_n, pk_r_n;
  logic [TALLY_W-1:0]  tally_q, tally_n;
  logic                close_blk;

  logic [LEVEL_W-1:0]  held_q [4];

  logic                out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                out_last_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign load_out  = (state_q == B_OUT) && slot_free;
  assign pop       = !q_empty_i && ((state_q == B_IDLE) || load_out);
  assign q_pop_o   = pop;

  // Magnitude of a 25-bit value; the most negative one maps to 2^24.
  assign mag_l = q_head_i.left_scaled[SCALED_W-1]
               ? LEVEL_W'(-q_head_i.left_scaled) : LEVEL_W'(q_head_i.left_scaled);
  assign mag_r = q_head_i.right_scaled[SCALED_W-1]
               ? LEVEL_W'(-q_head_i.right_scaled) : LEVEL_W'(q_head_i.right_scaled);

  always_comb begin
    add_l   = {1'b0, sum_l_q} + (SUM_W+1)'(sq_l_q);
    add_r   = {1'b0, sum_r_q} + (SUM_W+1)'(sq_r_q);
    sum_l_n = add_l[SUM_W] ? {SUM_W{1'b1}} : add_l[SUM_W-1:0];
    sum_r_n = cur_q.stereo ? (add_r[SUM_W] ? {SUM_W{1'b1}} : add_r[SUM_W-1:0]) : sum_r_q;
    pk_l_n  = (mag_l_q > pk_l_q) ? mag_l_q : pk_l_q;
    pk_r_n  = (cur_q.stereo && (mag_r_q > pk_r_q)) ? mag_r_q : pk_r_q;
    tally_n = tally_q + 1'b1;
    close_blk = cur_q.last_frame || (tally_n >= TALLY_W'(FRAME_LIMIT));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop) begin
          state_d = B_ACC;
        end
      end
      B_ACC: begin
        state_d = close_blk ? B_LEVEL : B_OUT;
      end
      B_LEVEL: begin
        if (lvl_stat_i.done) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (load_out) begin
          state_d = pop ? B_ACC : B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign lvl_start_o = (state_q == B_ACC) && close_blk;
  assign lvl_sum_l_o = sum_l_n;
  assign lvl_sum_r_o = sum_r_n;
  assign lvl_count_o = tally_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      pk_l_q      <= '0;
      pk_r_q      <= '0;
      tally_q     <= '0;
      held_q[0]   <= '0;
      held_q[1]   <= '0;
      held_q[2]   <= '0;
      held_q[3]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_ACC) begin
        if (close_blk) begin
          held_q[0] <= pk_l_n;
          held_q[1] <= cur_q.stereo ? pk_r_n : pk_l_n;
          sum_l_q   <= '0;
          sum_r_q   <= '0;
          pk_l_q    <= '0;
          pk_r_q    <= '0;
          tally_q   <= '0;
        end else begin
          sum_l_q <= sum_l_n;
          sum_r_q <= sum_r_n;
          pk_l_q  <= pk_l_n;
          pk_r_q  <= pk_r_n;
          tally_q <= tally_n;
        end
      end
      if (state_q == B_LEVEL && lvl_stat_i.done) begin
        held_q[2] <= lvl_root_l_i[LEVEL_W-1:0];
        held_q[3] <= cur_q.stereo ? lvl_root_r_i[LEVEL_W-1:0] : lvl_root_l_i[LEVEL_W-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q   <= q_head_i;
      mag_l_q <= mag_l;
      mag_r_q <= mag_r;
      sq_l_q  <= mag_l * mag_l;
      sq_r_q  <= mag_r * mag_r;
    end
    if (state_q == B_ACC) begin
      done_q <= close_blk;
    end
    if (load_out) begin
      out_data_q <= {2'b00, held_q[3], held_q[2], held_q[1], held_q[0],
                     cur_q.right_scaled, cur_q.left_scaled};
      out_last_q <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/core/gain_peak_rms_meter.sv =====
`timescale 1ns / 1ps

// Gain stage with a per-block stereo peak and RMS meter.
//
// Frames enter on the s_axis stream: two signed Q1.23 samples in tdata and
// tlast marking the final frame of a block. Each accepted frame yields exactly
// one transaction on the m_axis stream carrying both samples scaled by the
// master gain (Q2.14), the held peak and RMS levels, and tlast set when that
// frame closed a block so the levels are fresh. A block also closes on the
// frame that brings the count to the FRAME_LIMIT parameter.
// Gain and channel count are written on the cfg channel, which is always
// ready; index 0 is the gain (clamped to 2.0), index 1 the channel count.
// A two-entry queue decouples the input side from the metering engine. On an
// idle engine an ordinary frame goes from its input transaction through the
// queue and the accumulate and output states into the output register; the
// engine takes the next frame as it loads the output register. A frame that
// closes a block first runs the divide and root unit (division by the frame
// count, then the square root) on its way to the output register.
// Reset clears the accumulators, the held levels, the queue and the output
// valid flag, and restores unity gain and stereo mode. When the receiver
// stalls, the result waits in the output register while the engine goes on
// with the next frame; the input side stalls once the queue fills.

module gain_peak_rms_meter
  import gprm_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input frames.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: left_sample [23:0], right_sample [47:24]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  // Results.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: left_scaled [24:0], right_scaled [49:25], peak_left_level [74:50],
  // peak_right_level [99:75], rms_left_level [124:100],
  // rms_right_level [149:125], zero pad [151:150]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tlast: block_done
  output logic                   m_axis_tlast
);

  // The frame counter must hold the frame limit itself.
  localparam int unsigned TALLY_W = $clog2(FRAME_LIMIT + 1);

  logic               q_push, q_pop, q_full, q_empty;
  frame_t             q_entry, q_head;
  logic               lvl_start;
  logic [SUM_W-1:0]   lvl_sum_l, lvl_sum_r;
  logic [TALLY_W-1:0] lvl_count;
  lvl_stat_t          lvl_stat;
  logic [ROOT_W-1:0]  lvl_root_l, lvl_root_r;

  // Front: configuration, gain multiply and classification into the queue.
  gprm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  gprm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // Back: accumulation, block close and the output register.
  gprm_back #(
    .FRAME_LIMIT (FRAME_LIMIT),
    .TALLY_W     (TALLY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .lvl_start_o  (lvl_start),
    .lvl_sum_l_o  (lvl_sum_l),
    .lvl_sum_r_o  (lvl_sum_r),
    .lvl_count_o  (lvl_count),
    .lvl_stat_i   (lvl_stat),
    .lvl_root_l_i (lvl_root_l),
    .lvl_root_r_i (lvl_root_r),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // Mean-square division and square root, both channels side by side.
  gprm_level #(
    .TALLY_W (TALLY_W)
  ) u_level (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lvl_start),
    .sum_l_i  (lvl_sum_l),
    .sum_r_i  (lvl_sum_r),
    .count_i  (lvl_count),
    .stat_o   (lvl_stat),
    .root_l_o (lvl_root_l),
    .root_r_o (lvl_root_r)
  );

  // The back part never launches a block close while the level unit works.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_start |-> !lvl_stat.busy)
    else $error("level unit started while busy");

  // Completion is only reported at the end of a running computation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_stat.done |-> $past(lvl_stat.busy))
    else $error("level completion without a running computation");

  // No new result appears while the levels of a closing block are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_stat.busy |=> !$rose(m_axis_tvalid))
    else $error("result issued before block levels were ready");

endmodule
